/* hw/rtl/lms_pkg.sv */
`timescale 1ns / 1ps

package lms_pkg;

   typedef enum logic [1:0] {
      PH_HBLANK = 2'd0,
      PH_VBLANK = 2'd1,
      PH_OAM    = 2'd2,
      PH_XFER   = 2'd3
   } phase_type;

   localparam int unsigned ACC_W  = 16;
   localparam int unsigned LINE_W = 8;

   localparam logic [ACC_W-1:0]  LEN_OAM    = ACC_W'(80);
   localparam logic [ACC_W-1:0]  LEN_XFER   = ACC_W'(172);
   localparam logic [ACC_W-1:0]  LEN_HBLANK = ACC_W'(204);
   localparam logic [ACC_W-1:0]  LEN_LINE   = ACC_W'(456);
   localparam logic [ACC_W-1:0]  ACC_MAX    = {ACC_W{1'b1}};

   localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = LINE_W'(144);
   localparam logic [LINE_W-1:0] WRAP_LINE         = LINE_W'(153);

   typedef struct packed {
      phase_type         phase;
      logic [LINE_W-1:0] line;
      logic              line_match;
      logic              vblank_irq;
      logic              status_irq;
      logic              line_done;
      logic              display_off;
   } result_type;

endpackage

/* hw/rtl/lcd_mode_sequencer_unit.sv */
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// req      in         req_valid / req_ready  elapsed_cycles, lcd_on, compare_line,
//                                            compare_irq_enable
// rsp      out        rsp_valid / rsp_ready  phase, line, line_match, vblank_irq,
//                                            status_irq, line_done, display_off
//
// one transaction per clock while req_ready is high; the timing state is updated in the
// cycle of acceptance and its result is registered in the result or skid register, so the
// throughput is set by the single add, compare and subtract on the cycle accumulator
// a two-entry output (result register plus skid register) keeps req_ready high
// while one result waits; req_ready drops only when both are full
// synchronous active-high reset: accumulator 0, oam search, line 0, no results held

module lcd_mode_sequencer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [9:0] req_elapsed_cycles,
   input  logic       req_lcd_on,
   input  logic [7:0] req_compare_line,
   input  logic       req_compare_irq_enable,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_phase,
   output logic [7:0] rsp_line,
   output logic       rsp_line_match,
   output logic       rsp_vblank_irq,
   output logic       rsp_status_irq,
   output logic       rsp_line_done,
   output logic       rsp_display_off
);

   logic [lms_pkg::ACC_W-1:0]  acc_ff, acc_in;
   lms_pkg::phase_type         phase_ff, phase_in;
   logic [lms_pkg::LINE_W-1:0] line_ff, line_in;
   logic                       match_ff, match_in;

   lms_pkg::result_type        out_ff, skid_ff, res_in;
   logic                       out_valid_ff, skid_valid_ff;

   logic [lms_pkg::ACC_W:0]    acc_sum;
   logic [lms_pkg::ACC_W-1:0]  acc_sat;
   logic [lms_pkg::ACC_W-1:0]  phase_len;
   logic                       phase_step;
   logic [lms_pkg::LINE_W-1:0] line_inc;
   logic                       req_take;
   logic                       rsp_take;

   assign req_ready = !skid_valid_ff;
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = out_valid_ff && rsp_ready;

   assign acc_sum  = {1'b0, acc_ff} + (lms_pkg::ACC_W + 1)'(req_elapsed_cycles);
   assign acc_sat  = acc_sum[lms_pkg::ACC_W] ? lms_pkg::ACC_MAX
                                             : acc_sum[lms_pkg::ACC_W-1:0];
   assign line_inc = line_ff + lms_pkg::LINE_W'(1);

   always_comb begin
      unique case (phase_ff)
         lms_pkg::PH_HBLANK: phase_len = lms_pkg::LEN_HBLANK;
         lms_pkg::PH_VBLANK: phase_len = lms_pkg::LEN_LINE;
         lms_pkg::PH_OAM:    phase_len = lms_pkg::LEN_OAM;
         default:            phase_len = lms_pkg::LEN_XFER;
      endcase
   end

   assign phase_step = acc_sat >= phase_len;

   always_comb begin
      acc_in   = acc_sat;
      phase_in = phase_ff;
      line_in  = line_ff;
      match_in = match_ff;
      res_in   = '0;
      if (!req_lcd_on) begin
         line_in            = '0;
         res_in.display_off = 1'b1;
      end else if (phase_step) begin
         acc_in = acc_sat - phase_len;
         unique case (phase_ff)
            lms_pkg::PH_HBLANK: begin
               line_in = line_inc;
               if (line_inc == lms_pkg::FIRST_VBLANK_LINE) begin
                  phase_in          = lms_pkg::PH_VBLANK;
                  res_in.vblank_irq = 1'b1;
               end else begin
                  phase_in = lms_pkg::PH_OAM;
               end
            end
            lms_pkg::PH_VBLANK: begin
               if (line_inc >= lms_pkg::WRAP_LINE) begin
                  line_in  = '0;
                  phase_in = lms_pkg::PH_OAM;
               end else begin
                  line_in = line_inc;
               end
            end
            lms_pkg::PH_OAM: begin
               phase_in = lms_pkg::PH_XFER;
            end
            default: begin
               phase_in         = lms_pkg::PH_HBLANK;
               res_in.line_done = 1'b1;
            end
         endcase
         // line change: recompute coincidence on the new line
         if (phase_ff == lms_pkg::PH_HBLANK || phase_ff == lms_pkg::PH_VBLANK) begin
            match_in          = line_in == req_compare_line;
            res_in.status_irq = match_in && req_compare_irq_enable;
         end
      end
      res_in.phase      = phase_in;
      res_in.line       = line_in;
      res_in.line_match = match_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         phase_ff      <= lms_pkg::PH_OAM;
         line_ff       <= '0;
         match_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            acc_ff   <= acc_in;
            phase_ff <= phase_in;
            line_ff  <= line_in;
            match_ff <= match_in;
         end
         priority if (req_take && (!out_valid_ff || rsp_take)) begin
            out_valid_ff <= 1'b1;
         end else if (req_take) begin
            skid_valid_ff <= 1'b1;
         end else if (rsp_take && skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= out_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (req_take && (!out_valid_ff || rsp_take)) begin
         out_ff <= res_in;
      end else if (req_take) begin
         skid_ff <= res_in;
      end else if (rsp_take && skid_valid_ff) begin
         out_ff <= skid_ff;
      end else begin
         out_ff <= out_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_phase       = out_ff.phase;
   assign rsp_line        = out_ff.line;
   assign rsp_line_match  = out_ff.line_match;
   assign rsp_vblank_irq  = out_ff.vblank_irq;
   assign rsp_status_irq  = out_ff.status_irq;
   assign rsp_line_done   = out_ff.line_done;
   assign rsp_display_off = out_ff.display_off;

endmodule

/* tb/lcd_mode_sequencer_unit_tb.sv */
`timescale 1ns / 1ps

module lcd_mode_sequencer_unit_tb;

   class lcd_timing_scoreboard;
      logic [lms_pkg::ACC_W-1:0]  acc_cycles;
      lms_pkg::phase_type         phase_now;
      logic [lms_pkg::LINE_W-1:0] line_now;
      logic                       coincident;
      lms_pkg::result_type        expected_results[$];
      int                         mismatches;

      function new();
         acc_cycles = '0;
         phase_now  = lms_pkg::PH_OAM;
         line_now   = '0;
         coincident = 1'b0;
         mismatches = 0;
      endfunction

      task report(string msg);
         mismatches++;
         $display("%0t mismatch: %s", $time, msg);
      endtask

      // advance the line timing by one accepted transaction
      function void note_request(logic [9:0] elapsed, logic on, logic [7:0] cmp,
                                 logic en);
         logic [lms_pkg::ACC_W:0] sum;
         lms_pkg::result_type     r;
         bit                      line_changed;
         sum = {1'b0, acc_cycles} + (lms_pkg::ACC_W + 1)'(elapsed);
         acc_cycles = (sum > {1'b0, lms_pkg::ACC_MAX}) ? lms_pkg::ACC_MAX
                                                       : sum[lms_pkg::ACC_W-1:0];
         r = '0;
         line_changed = 1'b0;
         if (!on) begin
            line_now = '0;
            r.display_off = 1'b1;
         end else begin
            case (phase_now)
               lms_pkg::PH_HBLANK: begin
                  if (acc_cycles >= lms_pkg::LEN_HBLANK) begin
                     line_now = line_now + 1'b1;
                     if (line_now == lms_pkg::FIRST_VBLANK_LINE) begin
                        phase_now = lms_pkg::PH_VBLANK;
                        r.vblank_irq = 1'b1;
                     end else begin
                        phase_now = lms_pkg::PH_OAM;
                     end
                     acc_cycles = acc_cycles - lms_pkg::LEN_HBLANK;
                     line_changed = 1'b1;
                  end
               end
               lms_pkg::PH_VBLANK: begin
                  if (acc_cycles >= lms_pkg::LEN_LINE) begin
                     line_now = line_now + 1'b1;
                     if (line_now >= lms_pkg::WRAP_LINE) begin
                        line_now = '0;
                        phase_now = lms_pkg::PH_OAM;
                     end
                     acc_cycles = acc_cycles - lms_pkg::LEN_LINE;
                     line_changed = 1'b1;
                  end
               end
               lms_pkg::PH_OAM: begin
                  if (acc_cycles >= lms_pkg::LEN_OAM) begin
                     phase_now = lms_pkg::PH_XFER;
                     acc_cycles = acc_cycles - lms_pkg::LEN_OAM;
                  end
               end
               default: begin
                  if (acc_cycles >= lms_pkg::LEN_XFER) begin
                     phase_now = lms_pkg::PH_HBLANK;
                     acc_cycles = acc_cycles - lms_pkg::LEN_XFER;
                     r.line_done = 1'b1;
                  end
               end
            endcase
            if (line_changed) begin
               coincident = (line_now == cmp);
               r.status_irq = coincident && en;
            end
         end
         r.phase = phase_now;
         r.line = line_now;
         r.line_match = coincident;
         expected_results.push_back(r);
      endfunction

      task compare_field(string name, int unsigned got, int unsigned want);
         if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task check_response(lms_pkg::result_type got);
         lms_pkg::result_type want;
         if (expected_results.size() == 0) begin
            report("result with no transaction outstanding");
         end else begin
            want = expected_results.pop_front();
            compare_field("phase", got.phase, want.phase);
            compare_field("line", got.line, want.line);
            compare_field("line_match", got.line_match, want.line_match);
            compare_field("vblank_irq", got.vblank_irq, want.vblank_irq);
            compare_field("status_irq", got.status_irq, want.status_irq);
            compare_field("line_done", got.line_done, want.line_done);
            compare_field("display_off", got.display_off, want.display_off);
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [9:0] req_elapsed_cycles = '0;
   logic       req_lcd_on = 1'b0;
   logic [7:0] req_compare_line = '0;
   logic       req_compare_irq_enable = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_phase;
   logic [7:0] rsp_line;
   logic       rsp_line_match;
   logic       rsp_vblank_irq;
   logic       rsp_status_irq;
   logic       rsp_line_done;
   logic       rsp_display_off;

   bit no_idle = 1'b0;
   lcd_timing_scoreboard sb = new();

   lcd_mode_sequencer_unit dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_elapsed_cycles     (req_elapsed_cycles),
      .req_lcd_on             (req_lcd_on),
      .req_compare_line       (req_compare_line),
      .req_compare_irq_enable (req_compare_irq_enable),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_phase              (rsp_phase),
      .rsp_line               (rsp_line),
      .rsp_line_match         (rsp_line_match),
      .rsp_vblank_irq         (rsp_vblank_irq),
      .rsp_status_irq         (rsp_status_irq),
      .rsp_line_done          (rsp_line_done),
      .rsp_display_off        (rsp_display_off)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      lms_pkg::result_type got;
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_elapsed_cycles, req_lcd_on, req_compare_line,
                            req_compare_irq_enable);
         if (rsp_valid && rsp_ready) begin
            got.phase       = lms_pkg::phase_type'(rsp_phase);
            got.line        = rsp_line;
            got.line_match  = rsp_line_match;
            got.vblank_irq  = rsp_vblank_irq;
            got.status_irq  = rsp_status_irq;
            got.line_done   = rsp_line_done;
            got.display_off = rsp_display_off;
            sb.check_response(got);
         end
      end
   end

   task automatic send_timing(input logic [9:0] elapsed, input logic on,
                              input logic [7:0] cmp, input logic en);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid              <= 1'b1;
      req_elapsed_cycles     <= elapsed;
      req_lcd_on             <= on;
      req_compare_line       <= cmp;
      req_compare_irq_enable <= en;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      logic [9:0] elapsed;
      logic       on;
      logic [7:0] cmp;
      logic       en;
      int         sel;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // phase boundaries, display off and the field extremes
      send_timing(10'd0, 1'b1, 8'd0, 1'b1);
      send_timing(10'd79, 1'b1, 8'd0, 1'b0);
      send_timing(10'd1, 1'b1, 8'd255, 1'b1);
      send_timing(10'd171, 1'b1, 8'd0, 1'b1);
      send_timing(10'd1, 1'b1, 8'd0, 1'b1);
      send_timing(10'd203, 1'b1, 8'd1, 1'b1);
      send_timing(10'd1, 1'b1, 8'd1, 1'b1);
      send_timing(10'd0, 1'b0, 8'd255, 1'b1);
      send_timing(10'd1023, 1'b0, 8'd0, 1'b0);
      send_timing(10'd0, 1'b1, 8'd0, 1'b1);
      send_timing(10'd0, 1'b1, 8'd0, 1'b1);
      send_timing(10'd0, 1'b1, 8'd1, 1'b0);
      send_timing(10'd1023, 1'b1, 8'd2, 1'b1);
      send_timing(10'd512, 1'b1, 8'd255, 1'b0);

      // a full frame with the display running, then some toggling of the enable
      for (int i = 0; i < 460; i++) begin
         no_idle = (i >= 120 && i < 260);
         on = (i < 450) ? 1'b1 : 1'($urandom_range(1));
         sel = $urandom_range(99);
         if (sel < 70) elapsed = 10'($urandom_range(1023));
         else if (sel < 85) elapsed = 10'($urandom_range(15));
         else elapsed = 10'($urandom_range(1023, 1000));
         cmp = ($urandom_range(2) == 0) ? sb.line_now + 1'b1 : 8'($urandom_range(255));
         en = 1'($urandom_range(1));
         send_timing(elapsed, on, cmp, en);
      end
      no_idle = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/lms_pkg.sv
hw/rtl/lcd_mode_sequencer_unit.sv
tb/lcd_mode_sequencer_unit_tb.sv
